>>> src/b2t_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2t_pkg: shared types and constants for the binary to text converter
// Holds the controller state type and the ASCII digit lookup.
// ----------------------------------------------------------------------------
package b2t_pkg;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CHAR_W   = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A_OFF = 7'h57;  // 'a' - 10
  localparam logic [DIGIT_W-1:0] NIB_TEN   = 4'd10;
  localparam logic [DIGIT_W-1:0] BCD_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_THREE = 4'd3;

  // One digit (0..15) to its lower-case ASCII code
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W - DIGIT_W){1'b0}}, nib};
    if (nib < NIB_TEN) begin
      digit_to_ascii = CHAR_ZERO + ext;
    end else begin
      digit_to_ascii = CHAR_A_OFF + ext;
    end
  endfunction

endpackage

>>> src/binary_to_decimal_or_hex_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_or_hex_text: unsigned binary to ASCII digit stream
// Converts one value per word to decimal or lower-case hex text, most
// significant digit first, leading zeros suppressed, last digit marked.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one word: in_op selects the
//   radix (0 decimal, 1 hex) and in_value holds the number. in_stall is high
//   while a word is being converted or its digits are still going out, so
//   one word is handled at a time.
//   Output channel (out_valid / out_stall) carries one character per word
//   in out_digit_char, with out_last set on the least significant digit.
//   Decimal words pass through a double-dabble shifter, one input bit per
//   cycle, then the BCD register is shifted out one digit per cycle:
//   leading zeros are skipped, the others emitted while the receiver
//   does not stall. Hex words skip the conversion and go straight to the
//   digit shifter. The bit-serial conversion sets the decimal rate.
//   A stalled receiver holds the output register; the digit shifter waits,
//   but leading zeros are still skipped. Reset (synchronous, rst_n low)
//   returns to idle and drops out_valid.
module binary_to_decimal_or_hex_text #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [VALUE_WIDTH-1:0]     in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [b2t_pkg::CHAR_W-1:0] out_digit_char,
  output logic                       out_last
);
  import b2t_pkg::*;

  // Decimal digits needed: floor(W * log10 2) + 1
  localparam int unsigned DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned HEX_W      = HEX_DIGITS * DIGIT_W;
  localparam int unsigned DW         = DEC_DIGITS * DIGIT_W;
  localparam int unsigned CW         = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RW         = $clog2(DEC_DIGITS + 1);

  state_t                  state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]  bin_r, bin_nxt;
  logic [DW-1:0]           dig_r, dig_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [RW-1:0]           rem_r, rem_nxt;
  logic                    started_r, started_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_fire;
  logic                    slot_free;
  logic                    emit_fire;
  logic                    skip;
  logic [DIGIT_W-1:0]      top_nib;
  logic [DW-1:0]           dig_adj;
  logic [HEX_W-1:0]        hex_load;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_fire        = in_valid && !in_stall;
  assign slot_free      = !out_valid_r || !out_stall;
  assign top_nib        = dig_r[DW-1 -: DIGIT_W];
  assign skip           = (state_r == ST_EMIT) && !started_r && (top_nib == '0)
                          && (rem_r != RW'(1));
  assign emit_fire      = (state_r == ST_EMIT) && !skip && slot_free;
  assign hex_load       = HEX_W'(in_value);

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  // Double-dabble correction: add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig_r[i*DIGIT_W +: DIGIT_W] >= BCD_FIVE) begin
        dig_adj[i*DIGIT_W +: DIGIT_W] = dig_r[i*DIGIT_W +: DIGIT_W] + BCD_THREE;
      end else begin
        dig_adj[i*DIGIT_W +: DIGIT_W] = dig_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Sequencer and digit shifter
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          started_nxt = 1'b0;
          if (in_op) begin
            dig_nxt   = DW'(hex_load) << (DW - HEX_W);
            rem_nxt   = RW'(HEX_DIGITS);
            state_nxt = ST_EMIT;
          end else begin
            bin_nxt   = in_value;
            dig_nxt   = '0;
            cnt_nxt   = CW'(VALUE_WIDTH);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        // one binary bit into the BCD register per cycle
        dig_nxt = {dig_adj[DW-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          rem_nxt   = RW'(DEC_DIGITS);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          dig_nxt = dig_r << DIGIT_W;
          rem_nxt = rem_r - RW'(1);
        end else if (emit_fire) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(top_nib);
          out_last_nxt  = (rem_r == RW'(1));
          started_nxt   = 1'b1;
          dig_nxt       = dig_r << DIGIT_W;
          rem_nxt       = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= CHAR_ZERO && out_char_r <= 7'h66))
    else $error("output character out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && rem_r == RW'(1)) |=> (state_r == ST_IDLE && out_last_r))
    else $error("final digit did not close the run");

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (cnt_r != '0))
    else $error("conversion counter underflow");

  a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r != '0))
    else $error("digit counter underflow");

endmodule

>>> verif/binary_to_decimal_or_hex_text_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_or_hex_text_tb: self-checking bench for the text converter
// Offers numbers in decimal and hex mode and predicts the digit words of each
// accepted number. Every digit word is checked against the oldest prediction.
// Runs a directed set of edge values, then random values under three idling
// mixes, with one long receiver hold-off and drain pauses between phases.
// ----------------------------------------------------------------------------
module binary_to_decimal_or_hex_text_tb;

  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned CHAR_W         = b2t_pkg::CHAR_W;
  localparam int unsigned HEX_DIGITS     = (VALUE_W + 3) / 4;
  localparam int          RAND_PER_PHASE = 130;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 120;

  localparam logic [CHAR_W-1:0] ASCII_0 = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A = 7'h61;
  localparam logic [63:0]       VALUE_MASK = {64{1'b1}} >> (64 - VALUE_W);

  typedef enum logic {
    RADIX_DEC = 1'b0,
    RADIX_HEX = 1'b1
  } radix_t;

  typedef struct {
    radix_t      radix;
    logic [63:0] value;
  } conv_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_word_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_op     = 1'b0;
  logic [VALUE_W-1:0] in_value  = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last;

  conv_req_t   conv_req_q[$];
  digit_word_t digit_exp_q[$];

  int send_idle_pct = 21;
  int recv_idle_pct = 49;
  int rx_hold_req   = 0;
  int err_cnt       = 0;

  binary_to_decimal_or_hex_text #(
    .VALUE_WIDTH(VALUE_W)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  always #4 clk = ~clk;

  // Digit value 0..15 to its lower-case character
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W - 4){1'b0}}, d};
    if (d < 4'd10) begin
      return ASCII_0 + ext;
    end
    return ASCII_A + ext - 7'd10;
  endfunction

  // Expected digit words of one number, most significant first
  function automatic void push_digits(input radix_t radix, input logic [63:0] raw);
    logic [63:0]  v;
    logic [3:0]   dec_digit[20];
    digit_word_t  w;
    int           n;
    int           first;
    int           pos;
    v = raw & VALUE_MASK;
    n = 0;
    if (radix == RADIX_DEC) begin
      if (v == 64'd0) begin
        w.ch   = ASCII_0;
        w.last = 1'b1;
        digit_exp_q.push_back(w);
      end else begin
        while (v != 64'd0) begin
          dec_digit[n] = 4'(v % 64'd10);
          v = v / 64'd10;
          n++;
        end
        for (pos = n - 1; pos >= 0; pos--) begin
          w.ch   = digit_ascii(dec_digit[pos]);
          w.last = (pos == 0);
          digit_exp_q.push_back(w);
        end
      end
    end else begin
      // most significant non-zero nibble, keeping at least one digit
      first = HEX_DIGITS - 1;
      while (first > 0 && ((v >> (4 * first)) & 64'hf) == 64'd0) begin
        first--;
      end
      for (pos = first; pos >= 0; pos--) begin
        w.ch   = digit_ascii(4'((v >> (4 * pos)) & 64'hf));
        w.last = (pos == 0);
        digit_exp_q.push_back(w);
      end
    end
  endfunction

  // Random number: mostly full width or shortened, some powers of ten and two or one less
  function automatic logic [63:0] next_value();
    logic [63:0] full;
    logic [63:0] p;
    logic [63:0] result;
    int          k;
    full = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0: begin
        p = 64'd1;
        k = $urandom_range(19, 0);
        repeat (k) p = p * 64'd10;
        result = ($urandom_range(1, 0) == 0) ? p : p - 64'd1;
      end
      1: begin
        p = 64'd1 << $urandom_range(63, 0);
        result = ($urandom_range(1, 0) == 0) ? p : p - 64'd1;
      end
      2, 3, 4: result = full;
      default: result = full >> $urandom_range(63, 0);
    endcase
    return result;
  endfunction

  function automatic void add_req(input radix_t radix, input logic [63:0] value);
    conv_req_t r;
    r.radix = radix;
    r.value = value;
    conv_req_q.push_back(r);
  endfunction

  // Sender: holds a stalled word, otherwise offers the next pending one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        push_digits(radix_t'(in_op), 64'(in_value));
      end
      if (!in_valid || !in_stall) begin
        if (conv_req_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_op    <= conv_req_q[0].radix;
          in_value <= conv_req_q[0].value[VALUE_W-1:0];
          conv_req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks digit words, stalls at random or for a long hold-off
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  always @(posedge clk) begin
    digit_word_t w;
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (digit_exp_q.size() == 0) begin
          $error("unexpected digit word: digit_char %h last %b", out_digit_char, out_last);
          err_cnt++;
        end else begin
          w = digit_exp_q.pop_front();
          if (out_digit_char !== w.ch) begin
            $error("digit_char mismatch: expected %h actual %h", w.ch, out_digit_char);
            err_cnt++;
          end
          if (out_last !== w.last) begin
            $error("last mismatch: expected %b actual %b", w.last, out_last);
            err_cnt++;
          end
        end
      end
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles without any word moving on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Wait until every word is sent and every digit has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (conv_req_q.size() != 0 || in_valid || digit_exp_q.size() != 0);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < RAND_PER_PHASE; i++) begin
      add_req(radix_t'($urandom_range(1, 0)), next_value());
    end
    // receiver blocks while the sender keeps offering
    if (long_hold) begin
      rx_hold_req++;
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero, one-digit, carries, widest values in both radices
    add_req(RADIX_DEC, 64'd0);
    add_req(RADIX_HEX, 64'd0);
    add_req(RADIX_DEC, 64'd1);
    add_req(RADIX_DEC, 64'd9);
    add_req(RADIX_DEC, 64'd10);
    add_req(RADIX_DEC, 64'd99);
    add_req(RADIX_DEC, 64'd100);
    add_req(RADIX_DEC, 64'd9999999999999999999);
    add_req(RADIX_DEC, 64'd10000000000000000000);
    add_req(RADIX_DEC, 64'd12345678901234567890);
    add_req(RADIX_DEC, {64{1'b1}});
    add_req(RADIX_DEC, 64'h8000000000000000);
    add_req(RADIX_DEC, 64'h5555555555555555);
    add_req(RADIX_DEC, 64'haaaaaaaaaaaaaaaa);
    add_req(RADIX_HEX, 64'd1);
    add_req(RADIX_HEX, 64'ha);
    add_req(RADIX_HEX, 64'hf);
    add_req(RADIX_HEX, 64'h10);
    add_req(RADIX_HEX, 64'h00000000ffffffff);
    add_req(RADIX_HEX, 64'h0123456789abcdef);
    add_req(RADIX_HEX, 64'hfedcba9876543210);
    add_req(RADIX_HEX, 64'h8000000000000000);
    add_req(RADIX_HEX, {64{1'b1}});
    add_req(RADIX_HEX, 64'h5555555555555555);
    wait_drained();

    run_phase(21, 49, 1'b0);
    run_phase(49, 21, 1'b0);
    run_phase(0, 0, 1'b1);

    // let any stray digit show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (digit_exp_q.size() != 0) begin
      $error("digit words never received: %0d", digit_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
